### src/register_rename_reorder_buffer_defines.svh
// Assertion macros shared by the rename / reorder buffer RTL.
// Included by the controller and datapath; needs clk and rst in scope.
`ifndef REGISTER_RENAME_REORDER_BUFFER_DEFINES_SVH
`define REGISTER_RENAME_REORDER_BUFFER_DEFINES_SVH

// Expression holds at every clock edge outside reset
`define RRROB_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define RRROB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rrrob_pkg.sv
// Shared types and constants for the rename map / reorder buffer block.
// No dependencies; imported by every module of the block.
package rrrob_pkg;

  // Sizing
  localparam int ARCH_REGS  = 64;
  localparam int ROB_DEPTH  = 64;
  localparam int MAX_RETIRE = 8;

  // Fixed field widths of the stream items
  localparam int REG_W  = 6;
  localparam int SEQ_W  = 32;
  localparam int MODE_W = 2;
  localparam int KIND_W = 3;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 64;

  // Derived widths
  localparam int TAG_W  = $clog2(ROB_DEPTH);
  localparam int ARCH_W = $clog2(ARCH_REGS);
  localparam int OCC_W  = $clog2(ROB_DEPTH + 1);
  localparam int RCNT_W = $clog2(MAX_RETIRE + 1);

  // Configuration registers
  localparam int RW_W       = 4;
  localparam int RE_W       = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic SEL_RETIRE_WIDTH = 1'b0;
  localparam logic SEL_ROB_ENTRIES  = 1'b1;
  localparam logic [RW_W-1:0] RETIRE_WIDTH_RST = RW_W'(1);
  localparam logic [RE_W-1:0] ROB_ENTRIES_RST  = RE_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_RENAME   = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_RETIRE   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RENAMED      = 3'd0,
    KIND_STALL        = 3'd1,
    KIND_COMPLETED    = 3'd2,
    KIND_RETIRED      = 3'd3,
    KIND_NONE_RETIRED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RET_CHECK,
    ST_RET_READ,
    ST_RET_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // item transfer on the input side
    logic exec;        // rename or complete: commit and load result
    logic ret_read;    // read head entry
    logic ret_load;    // load retired result, read map at its register
    logic ret_commit;  // free head entry
    logic ret_none;    // load "nothing retired" result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              ret_can;
    logic              ret_cnt_zero;
    logic              out_free;
  } sts_t;

endpackage

### src/rrrob_ctrl.sv
// Sequencer for the rename map / reorder buffer block.
// Depends on rrrob_pkg and the assertion macro header.
`include "register_rename_reorder_buffer_defines.svh"

module rrrob_ctrl
  import rrrob_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (sts.in_mode == MODE_RETIRE) begin
            state_next = ST_RET_CHECK;
          end else if (sts.in_mode inside {MODE_RENAME, MODE_COMPLETE}) begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RET_CHECK: begin
        if (sts.ret_can) begin
          state_next = ST_RET_READ;
        end else if (!sts.ret_cnt_zero || sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RET_READ: begin
        if (sts.out_free) begin
          state_next = ST_RET_COMMIT;
        end
      end
      ST_RET_COMMIT: begin
        state_next = ST_RET_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = sts.out_free;
      end
      ST_RET_CHECK: begin
        cmd.ret_read = sts.ret_can;
        cmd.ret_none = !sts.ret_can && sts.ret_cnt_zero && sts.out_free;
      end
      ST_RET_READ: begin
        cmd.ret_load = sts.out_free;
      end
      ST_RET_COMMIT: begin
        cmd.ret_commit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Checks
  `RRROB_ASSERT_HOLDS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `RRROB_ASSERT_NEXT(a_read_then_commit, state == ST_RET_READ && sts.out_free, state == ST_RET_COMMIT, "retired result loaded without commit")

endmodule

### src/rrrob_dp.sv
// Datapath: rename map, reorder buffer storage, pointers and result register.
// Depends on rrrob_pkg and the assertion macro header; driven by rrrob_ctrl.
`include "register_rename_reorder_buffer_defines.svh"

module rrrob_dp
  import rrrob_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [OCC_W-1:0]  size_use,
  input  logic [RCNT_W-1:0] width_use,
  input  logic [MODE_W-1:0] s_tuser,
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [KIND_W-1:0] m_tuser,
  output logic              m_tlast,
  input  cmd_t              cmd,
  output sts_t              sts
);

  typedef struct packed {
    logic             has_dst;
    logic [REG_W-1:0] dst;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  s1_tag;
    logic              s1_from;
    logic              s1_rdy;
    logic [REG_W-1:0]  s2_tag;
    logic              s2_from;
    logic              s2_rdy;
    logic [REG_W-1:0]  rob_tag;
    logic [SEQ_W-1:0]  seq;
    logic              has_dst;
    logic [REG_W-1:0]  dst;
    logic              last;
  } res_t;

  function automatic logic [TAG_W-1:0] advance(input logic [TAG_W-1:0] p,
                                               input logic [OCC_W-1:0] size);
    logic [OCC_W-1:0] n;
    n = OCC_W'(p) + 1'b1;
    return (n >= size) ? '0 : TAG_W'(n);
  endfunction

  // Input fields
  logic             in_has_src1, in_has_src2, in_has_dst;
  logic [REG_W-1:0] in_src1, in_src2, in_dst, in_done;
  logic [SEQ_W-1:0] in_seq;

  assign in_has_src1 = s_tdata[0];
  assign in_src1     = s_tdata[6:1];
  assign in_has_src2 = s_tdata[7];
  assign in_src2     = s_tdata[13:8];
  assign in_has_dst  = s_tdata[14];
  assign in_dst      = s_tdata[20:15];
  assign in_seq      = s_tdata[52:21];
  assign in_done     = s_tdata[58:53];

  // Held item
  logic [MODE_W-1:0] it_mode;
  logic              it_has_src1, it_has_src2, it_has_dst;
  logic [REG_W-1:0]  it_src1, it_src2, it_dst, it_done;
  logic [SEQ_W-1:0]  it_seq;

  // State
  logic [ARCH_REGS-1:0] map_valid;
  logic [TAG_W-1:0]     map_tag [ARCH_REGS];
  logic [TAG_W-1:0]     map_rd1, map_rd2;
  entry_t               entry_mem [ROB_DEPTH];
  entry_t               ent_rd;
  logic [ROB_DEPTH-1:0] entry_ready;
  logic [TAG_W-1:0]     head, tail;
  logic [OCC_W-1:0]     occ;
  logic [RCNT_W-1:0]    rcnt;
  res_t                 res;
  logic                 out_valid;

  // Derived control
  logic             full, do_rename, do_complete, dst_mapped, ret_clear, ret_last, load;
  logic             s1_mapped, s2_mapped;
  logic [TAG_W-1:0] nh;
  res_t             res_next;

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode     <= s_tuser;
      it_has_src1 <= in_has_src1;
      it_src1     <= in_src1;
      it_has_src2 <= in_has_src2;
      it_src2     <= in_src2;
      it_has_dst  <= in_has_dst;
      it_dst      <= in_dst;
      it_seq      <= in_seq;
      it_done     <= in_done;
    end
  end

  // Rename map tag memory: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      map_rd1 <= map_tag[ARCH_W'(in_src1)];
      map_rd2 <= map_tag[ARCH_W'(in_src2)];
    end else if (cmd.ret_load) begin
      map_rd1 <= map_tag[ARCH_W'(ent_rd.dst)];
    end
    if (do_rename && dst_mapped) begin
      map_tag[ARCH_W'(it_dst)] <= tail;
    end
  end

  // Reorder buffer entry memory
  always_ff @(posedge clk) begin
    if (cmd.ret_read) begin
      ent_rd <= entry_mem[head];
    end
    if (do_rename) begin
      entry_mem[tail] <= '{has_dst: it_has_dst,
                           dst:     it_has_dst ? it_dst : '0,
                           seq:     it_seq};
    end
  end

  // Lookup and commit decode
  always_comb begin
    full        = occ >= size_use;
    do_rename   = cmd.exec && (it_mode == MODE_RENAME) && !full;
    do_complete = cmd.exec && (it_mode == MODE_COMPLETE) &&
                  (32'(it_done) < 32'(size_use));
    dst_mapped  = it_has_dst && (32'(it_dst) < ARCH_REGS);
    s1_mapped   = it_has_src1 && (32'(it_src1) < ARCH_REGS) &&
                  map_valid[ARCH_W'(it_src1)];
    s2_mapped   = it_has_src2 && (32'(it_src2) < ARCH_REGS) &&
                  map_valid[ARCH_W'(it_src2)];
    nh          = advance(head, size_use);
    ret_last    = (RCNT_W'(rcnt + 1'b1) >= width_use) || (occ == OCC_W'(1)) ||
                  (nh == head) || !entry_ready[nh];
    ret_clear   = cmd.ret_commit && ent_rd.has_dst &&
                  (32'(ent_rd.dst) < ARCH_REGS) &&
                  map_valid[ARCH_W'(ent_rd.dst)] && (map_rd1 == head);
    load        = cmd.exec || cmd.ret_load || cmd.ret_none;
  end

  // Result selection
  always_comb begin
    res_next = '0;
    if (cmd.exec) begin
      res_next.last = 1'b1;
      case (it_mode)
        MODE_RENAME: begin
          if (full) begin
            res_next.kind = KIND_STALL;
          end else begin
            res_next.kind    = KIND_RENAMED;
            res_next.s1_tag  = !it_has_src1 ? '0 : s1_mapped ? REG_W'(map_rd1) : it_src1;
            res_next.s1_from = s1_mapped;
            res_next.s1_rdy  = s1_mapped ? entry_ready[map_rd1] : 1'b1;
            res_next.s2_tag  = !it_has_src2 ? '0 : s2_mapped ? REG_W'(map_rd2) : it_src2;
            res_next.s2_from = s2_mapped;
            res_next.s2_rdy  = s2_mapped ? entry_ready[map_rd2] : 1'b1;
            res_next.rob_tag = REG_W'(tail);
          end
        end
        MODE_COMPLETE: begin
          res_next.kind    = KIND_COMPLETED;
          res_next.rob_tag = it_done;
        end
        default: begin
          res_next.last = 1'b0;
        end
      endcase
    end else if (cmd.ret_load) begin
      res_next.kind    = KIND_RETIRED;
      res_next.rob_tag = REG_W'(head);
      res_next.seq     = ent_rd.seq;
      res_next.has_dst = ent_rd.has_dst;
      res_next.dst     = ent_rd.dst;
      res_next.last    = ret_last;
    end else if (cmd.ret_none) begin
      res_next.kind = KIND_NONE_RETIRED;
      res_next.last = 1'b1;
    end
  end

  // Control state: valid and ready bits, pointers, counts
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid   <= '0;
      entry_ready <= '0;
      head        <= '0;
      tail        <= '0;
      occ         <= '0;
      rcnt        <= '0;
    end else begin
      if (cmd.capture) begin
        rcnt <= '0;
      end
      if (do_rename) begin
        entry_ready[tail] <= 1'b0;
        if (dst_mapped) begin
          map_valid[ARCH_W'(it_dst)] <= 1'b1;
        end
        tail <= advance(tail, size_use);
        occ  <= occ + 1'b1;
      end
      if (do_complete) begin
        entry_ready[TAG_W'(it_done)] <= 1'b1;
      end
      if (cmd.ret_commit) begin
        if (ret_clear) begin
          map_valid[ARCH_W'(ent_rd.dst)] <= 1'b0;
        end
        entry_ready[head] <= 1'b0;
        head <= nh;
        occ  <= occ - 1'b1;
        rcnt <= rcnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res.kind;
  assign m_tlast  = res.last;
  assign m_tdata  = {3'b000, res.dst, res.has_dst, res.seq, res.rob_tag,
                     res.s2_rdy, res.s2_from, res.s2_tag,
                     res.s1_rdy, res.s1_from, res.s1_tag};

  // Status
  assign sts.in_mode      = s_tuser;
  assign sts.ret_can      = (rcnt < width_use) && (occ != '0) && entry_ready[head];
  assign sts.ret_cnt_zero = (rcnt == '0);
  assign sts.out_free     = !out_valid || m_tready;

  // Checks
  `RRROB_ASSERT_HOLDS(a_occ_bound, 32'(occ) <= ROB_DEPTH, "occupancy beyond buffer depth")
  `RRROB_ASSERT_HOLDS(a_load_free, !load || sts.out_free, "result loaded over an untaken result")
  `RRROB_ASSERT_NEXT(a_commit_dec, cmd.ret_commit, occ == $past(occ) - 1'b1, "retire did not free one entry")

endmodule

### src/register_rename_reorder_buffer.sv
// Top level of the register rename map with reorder buffer.
// Depends on rrrob_pkg, rrrob_ctrl and rrrob_dp; holds the APB registers.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  input    | in        | s_tvalid / s_tready   | s_tuser mode, s_tdata fields
//  result   | out       | m_tvalid / m_tready   | m_tuser kind, m_tdata, m_tlast
//  config   | in        | psel/penable/pready   | paddr, pwdata, prdata
//
// Rename and complete: result registered once the result register is free.
// Retire: head check, then three steps per freed entry (entry memory read,
// map memory read, commit); none ready at the first check gives a result.
// Items are taken only in idle, one at a time.
// Reset clears map valid bits, ready bits, pointers and occupancy at once.
// A result not taken holds the sequence at the step that loads the next one.

module register_rename_reorder_buffer
  import rrrob_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,  // has_src1, src1_reg, has_src2, src2_reg,
                                          // has_dst, dst_reg, seq_num, done_tag
  input  logic [MODE_W-1:0]     s_tuser,  // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,  // src1_tag, src1_from_rob, src1_ready,
                                          // src2_tag, src2_from_rob, src2_ready,
                                          // rob_tag, retired_seq, retired_has_dst,
                                          // retired_reg
  output logic [KIND_W-1:0]     m_tuser,  // kind
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RW_W-1:0]   retire_width;
  logic [RE_W-1:0]   rob_entries;
  logic [OCC_W-1:0]  size_use;
  logic [RCNT_W-1:0] width_use;
  logic              cfg_wr;
  cmd_t              cmd;
  sts_t              sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retire_width <= RETIRE_WIDTH_RST;
      rob_entries  <= ROB_ENTRIES_RST;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == SEL_ROB_ENTRIES) begin
        rob_entries <= pwdata[RE_W-1:0];
      end else begin
        retire_width <= pwdata[RW_W-1:0];
      end
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == SEL_ROB_ENTRIES) ? APB_DATA_W'(rob_entries)
                                                          : APB_DATA_W'(retire_width);

  // Clamp register values to the sizes in use
  always_comb begin
    if (rob_entries == '0) begin
      size_use = OCC_W'(1);
    end else if (32'(rob_entries) > ROB_DEPTH) begin
      size_use = OCC_W'(ROB_DEPTH);
    end else begin
      size_use = OCC_W'(rob_entries);
    end
    if (retire_width == '0) begin
      width_use = RCNT_W'(1);
    end else if (32'(retire_width) > MAX_RETIRE) begin
      width_use = RCNT_W'(MAX_RETIRE);
    end else begin
      width_use = RCNT_W'(retire_width);
    end
  end

  rrrob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrrob_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .size_use  (size_use),
    .width_use (width_use),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/register_rename_reorder_buffer_test.sv
// Self-checking testbench for register_rename_reorder_buffer: drives rename, complete and
// retire transfers, predicts every result in a scoreboard class and checks them in order.
// Depends on rrrob_pkg and the register_rename_reorder_buffer RTL.
module register_rename_reorder_buffer_test;
  import rrrob_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_RETIRE_WIDTH =
    APB_ADDR_W'(SEL_RETIRE_WIDTH) << REG_SEL_BIT;
  localparam logic [APB_ADDR_W-1:0] ADDR_ROB_ENTRIES =
    APB_ADDR_W'(SEL_ROB_ENTRIES) << REG_SEL_BIT;

  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 35;
  localparam int NUM_PHASES    = 8;
  localparam int FIXED_PHASES  = 6;
  localparam int PHASE_RW [FIXED_PHASES] = '{8, 0, 15, 3, 4, 1};
  localparam int PHASE_RE [FIXED_PHASES] = '{64, 0, 127, 4, 1, 2};

  // Input transfer payload, first field in the lowest bits
  typedef struct packed {
    logic [4:0]       pad;
    logic [REG_W-1:0] done_tag;
    logic [SEQ_W-1:0] seq_num;
    logic [REG_W-1:0] dst_reg;
    logic             has_dst;
    logic [REG_W-1:0] src2_reg;
    logic             has_src2;
    logic [REG_W-1:0] src1_reg;
    logic             has_src1;
  } insn_fields_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    insn_fields_t      f;
  } insn_t;

  // Result transfer payload, first field in the lowest bits
  typedef struct packed {
    logic [2:0]       pad;
    logic [REG_W-1:0] retired_reg;
    logic             retired_has_dst;
    logic [SEQ_W-1:0] retired_seq;
    logic [REG_W-1:0] rob_tag;
    logic             src2_ready;
    logic             src2_from_rob;
    logic [REG_W-1:0] src2_tag;
    logic             src1_ready;
    logic             src1_from_rob;
    logic [REG_W-1:0] src1_tag;
  } outcome_fields_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              last;
    outcome_fields_t   f;
  } outcome_t;

  // Rename map and reorder buffer predictor with the queue of expected results
  class rename_rob_model;
    logic [RW_W-1:0]  retire_width;
    logic [RE_W-1:0]  rob_entries;
    logic             map_valid [ARCH_REGS];
    logic [TAG_W-1:0] map_tag [ARCH_REGS];
    logic             ent_has_dst [ROB_DEPTH];
    logic [REG_W-1:0] ent_reg [ROB_DEPTH];
    logic [SEQ_W-1:0] ent_seq [ROB_DEPTH];
    logic             ent_ready [ROB_DEPTH];
    int               head;
    int               tail;
    int               occupancy;
    outcome_t         pending [$];
    int               mismatches;

    function new();
      retire_width = RETIRE_WIDTH_RST;
      rob_entries  = ROB_ENTRIES_RST;
      foreach (map_valid[i]) begin
        map_valid[i] = 1'b0;
        map_tag[i]   = '0;
      end
      foreach (ent_ready[i]) begin
        ent_ready[i]   = 1'b0;
        ent_has_dst[i] = 1'b0;
        ent_reg[i]     = '0;
        ent_seq[i]     = '0;
      end
      head       = 0;
      tail       = 0;
      occupancy  = 0;
      mismatches = 0;
    endfunction

    // Zero acts as one, oversize values clamp to the hardware depth
    function int size_in_use();
      if (rob_entries == 0) return 1;
      if (rob_entries > ROB_DEPTH) return ROB_DEPTH;
      return int'(rob_entries);
    endfunction

    function int width_in_use();
      if (retire_width == 0) return 1;
      if (retire_width > MAX_RETIRE) return MAX_RETIRE;
      return int'(retire_width);
    endfunction

    function int advance(int p);
      return (p + 1 >= size_in_use()) ? 0 : p + 1;
    endfunction

    // Tag of the k-th held entry counting from the head
    function int nth_held(int k);
      int p;
      p = head;
      repeat (k) p = advance(p);
      return p;
    endfunction

    // Append one expected result
    function void expect_result(outcome_t o);
      pending = {pending, o};
    endfunction

    function void set_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] val);
      if (addr == ADDR_RETIRE_WIDTH) retire_width = val[RW_W-1:0];
      else if (addr == ADDR_ROB_ENTRIES) rob_entries = val[RE_W-1:0];
    endfunction

    function void lookup(logic has, logic [REG_W-1:0] r, output logic [REG_W-1:0] tag,
                         output logic from_rob, output logic rdy);
      tag      = '0;
      from_rob = 1'b0;
      rdy      = 1'b1;
      if (has) begin
        tag = r;
        if (map_valid[r]) begin
          tag      = map_tag[r];
          from_rob = 1'b1;
          rdy      = ent_ready[map_tag[r]];
        end
      end
    endfunction

    // Apply one accepted item and queue the results it causes
    function void accept_item(insn_t it);
      outcome_t o;
      int       t;
      int       n;
      o      = '0;
      o.last = 1'b1;
      case (it.mode)
        MODE_RENAME: begin
          if (occupancy >= size_in_use()) begin
            o.kind = KIND_STALL;
            expect_result(o);
          end else begin
            // sources are looked up before the destination is mapped
            lookup(it.f.has_src1, it.f.src1_reg, o.f.src1_tag, o.f.src1_from_rob,
                   o.f.src1_ready);
            lookup(it.f.has_src2, it.f.src2_reg, o.f.src2_tag, o.f.src2_from_rob,
                   o.f.src2_ready);
            t = tail;
            ent_has_dst[t] = it.f.has_dst;
            ent_reg[t]     = it.f.has_dst ? it.f.dst_reg : '0;
            ent_seq[t]     = it.f.seq_num;
            ent_ready[t]   = 1'b0;
            if (it.f.has_dst) begin
              map_valid[it.f.dst_reg] = 1'b1;
              map_tag[it.f.dst_reg]   = TAG_W'(t);
            end
            tail = advance(t);
            occupancy++;
            o.kind      = KIND_RENAMED;
            o.f.rob_tag = REG_W'(t);
            expect_result(o);
          end
        end
        MODE_COMPLETE: begin
          // a tag outside the buffer in use is still answered
          if (int'(it.f.done_tag) < size_in_use()) ent_ready[it.f.done_tag] = 1'b1;
          o.kind      = KIND_COMPLETED;
          o.f.rob_tag = it.f.done_tag;
          expect_result(o);
        end
        MODE_RETIRE: begin
          n = 0;
          while (n < width_in_use() && occupancy > 0 && ent_ready[head]) begin
            o                   = '0;
            o.kind              = KIND_RETIRED;
            o.f.rob_tag         = REG_W'(head);
            o.f.retired_seq     = ent_seq[head];
            o.f.retired_has_dst = ent_has_dst[head];
            o.f.retired_reg     = ent_reg[head];
            expect_result(o);
            foreach (map_valid[r]) begin
              if (map_valid[r] && map_tag[r] == head) begin
                map_valid[r] = 1'b0;
                map_tag[r]   = '0;
              end
            end
            ent_ready[head] = 1'b0;
            head = advance(head);
            occupancy--;
            n++;
          end
          if (n == 0) begin
            o      = '0;
            o.kind = KIND_NONE_RETIRED;
            o.last = 1'b1;
            expect_result(o);
          end else begin
            pending[pending.size()-1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.last !== want.last || got.f !== want.f) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rename_rob_model rob_model;
  bit              gaps_on;
  int              quiet_cycles;

  register_rename_reorder_buffer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (gaps_on) m_tready <= ($urandom_range(99) >= 32);
    else m_tready <= 1'b1;
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      rob_model.check_result(outcome_t'({m_tuser, m_tlast, m_tdata}));
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("register_rename_reorder_buffer_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic insn_t mk(logic [MODE_W-1:0] mode, logic h1, int r1, logic h2, int r2,
                               logic hd, int d, logic [SEQ_W-1:0] seq, int done_tag);
    insn_t it;
    it.mode       = mode;
    it.f.pad      = '0;
    it.f.has_src1 = h1;
    it.f.src1_reg = REG_W'(r1);
    it.f.has_src2 = h2;
    it.f.src2_reg = REG_W'(r2);
    it.f.has_dst  = hd;
    it.f.dst_reg  = REG_W'(d);
    it.f.seq_num  = seq;
    it.f.done_tag = REG_W'(done_tag);
    return it;
  endfunction

  // Registers drawn mostly from a small set so that mappings get hit
  function automatic int arch_reg();
    return $urandom_range(1) ? $urandom_range(7) : $urandom_range(ARCH_REGS - 1);
  endfunction

  function automatic insn_t random_insn(logic [MODE_W-1:0] mode);
    return mk(mode, $urandom_range(3) != 0, arch_reg(), $urandom_range(3) != 0, arch_reg(),
              $urandom_range(3) != 0, arch_reg(), $urandom(), $urandom_range(63));
  endfunction

  // Mostly well-formed traffic: completes aim at held entries
  function automatic insn_t next_insn();
    insn_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      it = random_insn(MODE_RENAME);
    end else if (pick < 75) begin
      it = random_insn(MODE_COMPLETE);
      if (rob_model.occupancy > 0 && $urandom_range(9) != 0)
        it.f.done_tag = REG_W'(rob_model.nth_held($urandom_range(rob_model.occupancy - 1)));
    end else if (pick < 97) begin
      it = random_insn(MODE_RETIRE);
    end else begin
      it = random_insn(MODE_UNUSED);
    end
    return it;
  endfunction

  // One input transfer with optional idle cycles in front
  task automatic send(input insn_t it);
    while (gaps_on && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= it.f;
    do @(posedge clk); while (!s_tready);
    rob_model.accept_item(it);
  endtask

  task automatic wait_results(input bit settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (rob_model.pending.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rob_model.set_reg(addr, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Empty the buffer so that a size change never exposes unwritten entries
  task automatic drain_rob();
    int    held [$];
    insn_t it;
    for (int k = 0; k < rob_model.occupancy; k++) held = {held, rob_model.nth_held(k)};
    foreach (held[k]) begin
      it = random_insn(MODE_COMPLETE);
      it.f.done_tag = REG_W'(held[k]);
      send(it);
    end
    while (rob_model.occupancy != 0) send(random_insn(MODE_RETIRE));
    wait_results(1'b1);
  endtask

  // Bring the pointers of an empty buffer back to entry 0, so that a smaller
  // size never leaves the head on an entry that can no longer be completed
  task automatic rewind_rob();
    insn_t it;
    if (rob_model.head != 0) begin
      write_reg(ADDR_ROB_ENTRIES, APB_DATA_W'(rob_model.head + 1));
      send(random_insn(MODE_RENAME));
      it = random_insn(MODE_COMPLETE);
      it.f.done_tag = REG_W'(rob_model.head);
      send(it);
      send(random_insn(MODE_RETIRE));
      wait_results(1'b1);
    end
  endtask

  initial begin
    insn_t           it;
    int              count;
    logic [APB_DATA_W-1:0] rw;
    logic [APB_DATA_W-1:0] re;
    rob_model = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = '0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: one retire per item, full depth
    send(mk(MODE_RETIRE,   0, 0,  0, 0,  0, 0,  32'h0, 0));   // retire with buffer empty
    send(mk(MODE_RENAME,   0, 0,  0, 0,  0, 0,  32'h0, 0));   // no sources, no destination
    send(mk(MODE_RENAME,   1, 63, 0, 0,  1, 63, 32'hffff_ffff, 63));
    send(mk(MODE_RENAME,   1, 63, 1, 0,  1, 0,  32'h1, 0));   // mapped source not ready
    send(mk(MODE_COMPLETE, 0, 0,  0, 0,  0, 0,  32'h0, 1));
    send(mk(MODE_RENAME,   1, 63, 1, 0,  1, 63, 32'h2, 0));   // ready source, remap dst
    send(mk(MODE_RETIRE,   0, 0,  0, 0,  0, 0,  32'h0, 0));   // head not ready
    send(mk(MODE_COMPLETE, 0, 0,  0, 0,  0, 0,  32'h0, 0));
    send(mk(MODE_COMPLETE, 0, 0,  0, 0,  0, 0,  32'h0, 63));  // entry not held
    send(mk(MODE_COMPLETE, 0, 0,  0, 0,  0, 0,  32'h0, 2));
    send(mk(MODE_UNUSED,   1, 5,  1, 6,  1, 7,  32'h5, 3));   // ignored, no result
    send(mk(MODE_RETIRE,   0, 0,  0, 0,  0, 0,  32'h0, 0));
    send(mk(MODE_RETIRE,   0, 0,  0, 0,  0, 0,  32'h0, 0));
    send(mk(MODE_RETIRE,   0, 0,  0, 0,  0, 0,  32'h0, 0));   // clears mapping of r0
    send(mk(MODE_RENAME,   1, 0,  1, 63, 0, 45, 32'h3, 0));   // dst absent, reg dropped
    send(mk(MODE_COMPLETE, 0, 0,  0, 0,  0, 0,  32'h0, 3));
    send(mk(MODE_RENAME,   1, 63, 1, 63, 1, 1,  32'h4, 0));
    drain_rob();

    // Random phases over a range of register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        rw = PHASE_RW[ph];
        re = PHASE_RE[ph];
      end else begin
        rw = $urandom_range(15);
        re = $urandom_range(20, 1);
      end
      rewind_rob();
      write_reg(ADDR_RETIRE_WIDTH, rw);
      write_reg(ADDR_ROB_ENTRIES, re);
      gaps_on = (ph != 3);
      count = 0;
      while (count < PHASE_ITEMS) begin
        it = next_insn();
        send(it);
        if (it.mode != MODE_UNUSED) begin
          count++;
          // sender holds off until every expected result has come back
          if (count == PHASE_ITEMS / 2) wait_results(1'b0);
        end
      end
      drain_rob();
    end

    wait_results(1'b1);
    if (rob_model.mismatches == 0 && rob_model.pending.size() == 0) begin
      $display("register_rename_reorder_buffer_test passed");
    end else begin
      $display("register_rename_reorder_buffer_test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/rrrob_pkg.sv
src/rrrob_ctrl.sv
src/rrrob_dp.sv
src/register_rename_reorder_buffer.sv
tb/sv/register_rename_reorder_buffer_test.sv
